@@ rtl/core/bcd_decimal_add_sub_compare_assert.svh @@
// Assertion macros for the packed-BCD add/subtract/compare block.
// Used by bcd_decimal_add_sub_compare.sv; no other dependencies.
`ifndef BCD_DECIMAL_ADD_SUB_COMPARE_ASSERT_SVH
`define BCD_DECIMAL_ADD_SUB_COMPARE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BDASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BDASC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bdasc_pkg.sv @@
// Package for the packed-BCD add/subtract/compare block: codes, widths
// and the per-digit add and subtract steps. No dependencies.
`timescale 1ns / 1ps

package bdasc_pkg;

    // Fixed field widths
    localparam int FIELD_W = 52;
    localparam int CMD_W   = 2;
    localparam int CODE_W  = 2;

    // Default digit count and digits resolved per pipeline stage
    localparam int DIGITS_DEF       = 13;
    localparam int DIGITS_PER_STAGE = 5;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CMP = 2'd2;

    // Status codes
    localparam logic [CODE_W-1:0] ST_OK  = 2'd0;
    localparam logic [CODE_W-1:0] ST_OVF = 2'd1;
    localparam logic [CODE_W-1:0] ST_NEG = 2'd2;

    // Ordering of a against b
    localparam logic [CODE_W-1:0] ORD_EQ = 2'd0;
    localparam logic [CODE_W-1:0] ORD_GT = 2'd1;
    localparam logic [CODE_W-1:0] ORD_LT = 2'd2;

    // One digit of result plus its carry or borrow
    typedef struct packed {
        logic [3:0] digit;
        logic [1:0] cy;
    } t_dig;

    // Decimal add of one digit; non-BCD nibbles can push the carry up to 3
    function automatic t_dig add_digit(input logic [3:0] a, input logic [3:0] b,
                                       input logic [1:0] cin);
        logic [5:0] s;
        t_dig       r;
        s = {2'b00, a} + {2'b00, b} + {4'b0000, cin};
        priority if (s >= 6'd30) begin
            r.cy    = 2'd3;
            r.digit = 4'(s - 6'd30);
        end else if (s >= 6'd20) begin
            r.cy    = 2'd2;
            r.digit = 4'(s - 6'd20);
        end else if (s >= 6'd10) begin
            r.cy    = 2'd1;
            r.digit = 4'(s - 6'd10);
        end else begin
            r.cy    = 2'd0;
            r.digit = s[3:0];
        end
        return r;
    endfunction

    // Decimal subtract of one digit; a negative difference borrows ten
    function automatic t_dig sub_digit(input logic [3:0] a, input logic [3:0] b,
                                       input logic bin);
        logic [5:0] d;
        logic [5:0] f;
        t_dig       r;
        d = {2'b00, a} - {2'b00, b} - {5'b00000, bin};
        f = d + 6'd10;
        if (d[5]) begin
            r.digit = f[3:0];
            r.cy    = 2'd1;
        end else begin
            r.digit = d[3:0];
            r.cy    = 2'd0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bcd_decimal_add_sub_compare.sv @@
// Packed-BCD add / subtract / compare, fully pipelined, no backpressure.
// Path: the input stage takes the start beat, then it runs through NSTG
// = ceil(DIGITS/5) carry stages and the output register to o_valid.
// Throughput: one beat per clock; busy is always low, the carry and
// ordering chains advance five digits per register stage.
// Reset (i_rst_n low, synchronous) clears the valid bits only.
`timescale 1ns / 1ps
`include "bcd_decimal_add_sub_compare_assert.svh"

module bcd_decimal_add_sub_compare #(
    parameter int DIGITS = bdasc_pkg::DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bdasc_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bdasc_pkg::FIELD_W-1:0] i_operand_a,
    input  logic [bdasc_pkg::FIELD_W-1:0] i_operand_b,
    output logic                         o_valid,
    output logic [bdasc_pkg::FIELD_W-1:0] o_value_out,
    output logic [bdasc_pkg::CODE_W-1:0] o_status,
    output logic [bdasc_pkg::CODE_W-1:0] o_order
);

    import bdasc_pkg::*;

    localparam int W    = 4 * DIGITS;
    localparam int GRP  = DIGITS_PER_STAGE;
    localparam int NSTG = (DIGITS + GRP - 1) / GRP;

    // Pipeline registers; index 0 is the input stage
    logic             r_vld [0:NSTG];
    logic [CMD_W-1:0] r_cmd [0:NSTG];
    logic [W-1:0]     r_a   [0:NSTG];
    logic [W-1:0]     r_b   [0:NSTG];
    logic [W-1:0]     r_res [0:NSTG];
    logic [1:0]       r_cy  [0:NSTG];
    logic [1:0]       r_ord [0:NSTG];

    logic [W-1:0] a_in;
    logic [W-1:0] b_in;

    // Output registers
    logic              r_out_vld;
    logic [W-1:0]      r_out_val;
    logic [CODE_W-1:0] r_out_st;
    logic [CODE_W-1:0] r_out_ord;
    logic [W-1:0]      n_out_val;
    logic [CODE_W-1:0] n_out_st;

    // Never stalls
    assign busy = 1'b0;

    // Fit operands to the digit count: drop or zero-fill upper digits
    generate
        if (W <= FIELD_W) begin : g_in_trunc
            assign a_in = i_operand_a[W-1:0];
            assign b_in = i_operand_b[W-1:0];
        end else begin : g_in_ext
            assign a_in = {{(W-FIELD_W){1'b0}}, i_operand_a};
            assign b_in = {{(W-FIELD_W){1'b0}}, i_operand_b};
        end
    endgenerate

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd[0] <= i_cmd;
        r_a[0]   <= a_in;
        r_b[0]   <= b_in;
        r_res[0] <= '0;
        r_cy[0]  <= 2'd0;
        r_ord[0] <= ORD_EQ;
    end

    // Carry stages: each resolves up to GRP digits, low to high
    generate
        for (genvar s = 1; s <= NSTG; s++) begin : g_stg
            localparam int LO  = (s - 1) * GRP;
            localparam int CNT = (DIGITS - LO < GRP) ? (DIGITS - LO) : GRP;

            logic [W-1:0] n_res;
            logic [1:0]   n_cy;
            logic [1:0]   n_ord;

            always_comb begin : c_digits
                t_dig       dg;
                logic [3:0] da;
                logic [3:0] db;
                n_res = r_res[s-1];
                n_cy  = r_cy[s-1];
                n_ord = r_ord[s-1];
                for (int k = 0; k < CNT; k++) begin
                    da = r_a[s-1][4*(LO+k) +: 4];
                    db = r_b[s-1][4*(LO+k) +: 4];
                    if (r_cmd[s-1] == CMD_SUB) begin
                        dg = sub_digit(da, db, n_cy[0]);
                    end else begin
                        dg = add_digit(da, db, n_cy);
                    end
                    n_res[4*(LO+k) +: 4] = dg.digit;
                    n_cy                 = dg.cy;
                    // a higher digit overrides any lower difference
                    if (da > db) begin
                        n_ord = ORD_GT;
                    end else if (da < db) begin
                        n_ord = ORD_LT;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= r_vld[s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_cmd[s] <= r_cmd[s-1];
                r_a[s]   <= r_a[s-1];
                r_b[s]   <= r_b[s-1];
                r_res[s] <= n_res;
                r_cy[s]  <= n_cy;
                r_ord[s] <= n_ord;
            end
        end
    endgenerate

    // Result selection and error handling
    always_comb begin
        n_out_val = '0;
        n_out_st  = ST_OK;
        unique case (r_cmd[NSTG])
            CMD_ADD: begin
                if (r_cy[NSTG] != 2'd0) begin
                    n_out_st = ST_OVF;
                end else begin
                    n_out_val = r_res[NSTG];
                end
            end
            CMD_SUB: begin
                if (r_ord[NSTG] == ORD_LT) begin
                    n_out_st = ST_NEG;
                end else begin
                    n_out_val = r_res[NSTG];
                end
            end
            CMD_CMP: begin
                n_out_val = '0;
                n_out_st  = ST_OK;
            end
            default: begin
                n_out_val = '0;
                n_out_st  = ST_OK;
            end
        endcase
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= n_out_val;
        r_out_st  <= n_out_st;
        r_out_ord <= r_ord[NSTG];
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_out_st;
    assign o_order  = r_out_ord;

    generate
        if (W >= FIELD_W) begin : g_out_trunc
            assign o_value_out = r_out_val[FIELD_W-1:0];
        end else begin : g_out_ext
            assign o_value_out = {{(FIELD_W-W){1'b0}}, r_out_val};
        end
    endgenerate

    // Checks
    `BDASC_ASSERT_NXT(a_last_to_out, i_clk, i_rst_n, r_vld[NSTG], o_valid, "beat lost at output")
    `BDASC_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_value_out == '0, "nonzero value on error")
    `BDASC_ASSERT_IMP(a_neg_order, i_clk, i_rst_n, o_valid && (o_status == ST_NEG), o_order == ORD_LT, "negative status without a < b")
    `BDASC_ASSERT_NXT(a_in_to_stg1, i_clk, i_rst_n, r_vld[0], r_vld[1], "beat lost in first stage")

endmodule
